// ===== rtl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue core.
`default_nettype none
package dq_pkg;

  localparam int DqDepth = 16;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_REAR   = 3'd3;
  localparam logic [2:0] KIND_LIST       = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] SEL_HOLD  = 2'd0;
  localparam logic [1:0] SEL_LEFT  = 2'd1;
  localparam logic [1:0] SEL_RIGHT = 2'd2;
  localparam logic [1:0] SEL_BUS   = 2'd3;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/dq_cell.sv =====
// One storage cell of the queue chain: holds a value or takes a neighbor's or the bus.
`default_nettype none
module dq_cell (
  input  wire                clk,
  input  wire  [1:0]         sel,
  input  wire  signed [31:0] left_data,
  input  wire  signed [31:0] right_data,
  input  wire  signed [31:0] bus_data,
  output logic signed [31:0] data
);
  import dq_pkg::*;

  always_ff @(posedge clk) begin
    case (sel)
      SEL_LEFT:  data <= left_data;
      SEL_RIGHT: data <= right_data;
      SEL_BUS:   data <= bus_data;
      default:   data <= data;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: cell chain, occupancy and response control.
//
//   channel | direction | handshake              | word
//   cmd     | in        | cmd_valid / cmd_stall  | kind, value
//   rsp     | out       | rsp_valid / rsp_stall  | item, status, last
//
// Push, pop and empty/full answers are one word each. A listing sends one word
// per cycle unless rsp stalls, occ words in all, reading cell 0 while the
// occupied cells rotate once; cmd stays stalled until the last word is registered.
// rst clears occupancy and control; cell contents are not cleared.
// A held rsp word stalls the command side too.
`default_nettype none
module double_ended_queue_core #(
  parameter int DEPTH = dq_pkg::DqDepth
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           cmd_valid,
  output logic          cmd_stall,
  input  wire dq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  wire           rsp_stall,
  output dq_pkg::rsp_t  rsp
);
  import dq_pkg::*;

  localparam int OccW = $clog2(DEPTH + 1);
  localparam int IdxW = $clog2(DEPTH);
  localparam logic [OccW-1:0] OccFull = OccW'(DEPTH);
  localparam logic [OccW-1:0] OccOne  = OccW'(1);

  logic [OccW-1:0] occ;
  logic [OccW-1:0] remaining;
  logic            busy;

  logic signed [31:0] cell_q [DEPTH];
  logic [1:0]         cell_sel [DEPTH];
  logic signed [31:0] bus_data;

  logic            can_emit;
  logic            accept;
  logic            full;
  logic            empty;
  logic [OccW-1:0] occ_m1;
  logic [IdxW-1:0] rear_idx;
  logic            push_front;
  logic            push_rear;
  logic            pop_front;
  logic            rotate;

  assign can_emit  = !rsp_valid || !rsp_stall;
  assign cmd_stall = busy || !can_emit;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (occ == OccFull);
  assign empty     = (occ == '0);
  assign occ_m1    = occ - OccOne;
  assign rear_idx  = occ_m1[IdxW-1:0];

  assign push_front = accept && (cmd.kind == KIND_PUSH_FRONT) && !full;
  assign push_rear  = accept && (cmd.kind == KIND_PUSH_REAR) && !full;
  assign pop_front  = accept && (cmd.kind == KIND_POP_FRONT) && !empty;
  assign rotate     = (accept && (cmd.kind == KIND_LIST) && !empty) || (busy && can_emit);

  assign bus_data = rotate ? cell_q[0] : cmd.value;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_sel[i] = SEL_HOLD;
      if (push_front) begin
        cell_sel[i] = (i == 0) ? SEL_BUS : SEL_LEFT;
      end
      if (push_rear && (OccW'(i) == occ)) begin
        cell_sel[i] = SEL_BUS;
      end
      if (pop_front) begin
        cell_sel[i] = SEL_RIGHT;
      end
      if (rotate) begin
        if (OccW'(i) == occ_m1) begin
          cell_sel[i] = SEL_BUS;
        end else if (OccW'(i) < occ_m1) begin
          cell_sel[i] = SEL_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_data;
    logic signed [31:0] right_data;
    if (g == 0) begin : g_first
      assign left_data = cmd.value;
    end else begin : g_mid_l
      assign left_data = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_q[g+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .sel        (cell_sel[g]),
      .left_data  (left_data),
      .right_data (right_data),
      .bus_data   (bus_data),
      .data       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      remaining <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (accept) begin
        case (cmd.kind)
          KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
            rsp_valid  <= 1'b1;
            rsp.item   <= '0;
            rsp.status <= full ? STATUS_FULL : STATUS_OK;
            rsp.last   <= 1'b1;
            if (!full) begin
              occ <= occ + OccOne;
            end
          end
          KIND_POP_FRONT, KIND_POP_REAR: begin
            rsp_valid <= 1'b1;
            rsp.last  <= 1'b1;
            if (empty) begin
              rsp.item   <= '0;
              rsp.status <= STATUS_EMPTY;
            end else begin
              rsp.item   <= (cmd.kind == KIND_POP_FRONT) ? cell_q[0] : cell_q[rear_idx];
              rsp.status <= STATUS_OK;
              occ        <= occ_m1;
            end
          end
          KIND_LIST: begin
            rsp_valid <= 1'b1;
            if (empty) begin
              rsp.item   <= '0;
              rsp.status <= STATUS_EMPTY;
              rsp.last   <= 1'b1;
            end else begin
              rsp.item   <= cell_q[0];
              rsp.status <= STATUS_OK;
              rsp.last   <= (occ == OccOne);
              busy       <= (occ != OccOne);
              remaining  <= occ_m1;
            end
          end
          default: begin
          end
        endcase
      end else if (busy && can_emit) begin
        rsp_valid  <= 1'b1;
        rsp.item   <= cell_q[0];
        rsp.status <= STATUS_OK;
        rsp.last   <= (remaining == OccOne);
        remaining  <= remaining - OccOne;
        if (remaining == OccOne) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/deque_sb_pkg.sv =====
// Scoreboard class for the double-ended queue core testbench.
package deque_sb_pkg;
  import dq_pkg::*;

  class deque_scoreboard;
    logic signed [31:0] ring_mem [DqDepth];
    int unsigned        front_idx;
    int unsigned        fill_count;
    rsp_t               deque_answers[$];
    int                 error_count;
    int                 cmds_noted;
    int                 ignored_cmds;
    int                 words_checked;
    int                 full_refusals;
    int                 empty_answers;
    int                 listed_words;

    function new();
      front_idx     = 0;
      fill_count    = 0;
      error_count   = 0;
      cmds_noted    = 0;
      ignored_cmds  = 0;
      words_checked = 0;
      full_refusals = 0;
      empty_answers = 0;
      listed_words  = 0;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
    endtask

    // Accepted command: update the deque copy and queue up its answer words (none for reserved kinds).
    function void apply_cmd(cmd_t c);
      rsp_t        w;
      int unsigned i;
      w      = '0;
      w.last = 1'b1;
      cmds_noted++;
      case (c.kind)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (fill_count >= DqDepth) begin
            w.status = STATUS_FULL;
            full_refusals++;
          end else if (c.kind == KIND_PUSH_FRONT) begin
            front_idx = (front_idx + DqDepth - 1) % DqDepth;
            ring_mem[front_idx] = c.value;
            fill_count++;
          end else begin
            ring_mem[(front_idx + fill_count) % DqDepth] = c.value;
            fill_count++;
          end
          deque_answers.push_back(w);
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (fill_count == 0) begin
            w.status = STATUS_EMPTY;
            empty_answers++;
          end else if (c.kind == KIND_POP_FRONT) begin
            w.item    = ring_mem[front_idx];
            front_idx = (front_idx + 1) % DqDepth;
            fill_count--;
          end else begin
            w.item = ring_mem[(front_idx + fill_count - 1) % DqDepth];
            fill_count--;
          end
          deque_answers.push_back(w);
        end
        KIND_LIST: begin
          if (fill_count == 0) begin
            w.status = STATUS_EMPTY;
            empty_answers++;
            deque_answers.push_back(w);
          end else begin
            for (i = 0; i < fill_count; i++) begin
              w.item = ring_mem[(front_idx + i) % DqDepth];
              w.last = (i + 1 == fill_count);
              deque_answers.push_back(w);
              listed_words++;
            end
          end
        end
        default: ignored_cmds++;
      endcase
    endfunction

    task check_answer(rsp_t got);
      rsp_t want;
      if (deque_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected word item=%0d status=%0d last=%0d",
                                  got.item, got.status, got.last));
        return;
      end
      want = deque_answers.pop_front();
      words_checked++;
      if (got.item !== want.item)
        report_mismatch($sformatf("item got %0d want %0d", got.item, want.item));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top-level testbench for the double-ended queue core: stimulus, stalls and checking.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;
  import deque_sb_pkg::*;

  localparam int         IDLE_LIMIT    = 2000;
  localparam int         RANDOM_ITEMS  = 160;
  localparam int         TAIL_ITEMS    = 40;
  localparam int         SETTLE_CYCLES = 20;
  localparam logic [2:0] KIND_RESERVED = 3'd5;

  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_BALANCE = 2;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic            quiet;
  int              idle_cycles;
  deque_scoreboard sb;

  double_ended_queue_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.apply_cmd(cmd);
      if (rsp_valid && !rsp_stall) sb.check_answer(rsp);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Response-side stall bursts, separated by calm stretches.
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    rsp_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_stall = 1'b1;
        stall_left--;
        if (stall_left == 0) calm_left = $urandom_range(0, 40);
      end else if (calm_left > 0) begin
        rsp_stall = 1'b0;
        calm_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rsp_stall  = 1'b1;
        stall_left = $urandom_range(1, 15) - 1;
        if (stall_left == 0) calm_left = $urandom_range(0, 40);
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  task automatic hold_off(int n);
    @(negedge clk);
    cmd_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_word(logic [2:0] kind, logic signed [31:0] value);
    cmd_t c;
    c.kind  = kind;
    c.value = value;
    if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 15));
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd       = c;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic drain_answers();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (sb.deque_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return ($urandom_range(0, 1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
  endfunction

  function automatic logic [2:0] pick_kind(int mode);
    int r;
    int push_pct;
    r        = $urandom_range(0, 99);
    push_pct = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 15 : 45;
    if (r < 3) return KIND_RESERVED + 3'($urandom_range(0, 2));
    if (r < 11) return KIND_LIST;
    if (r < 11 + push_pct) return pick_push();
    return ($urandom_range(0, 1) == 0) ? KIND_POP_FRONT : KIND_POP_REAR;
  endfunction

  initial begin
    int         done;
    int         mode;
    logic [2:0] kind;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    quiet     = 1'b0;
    sb        = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty deque, single-element pops, value extremes, reserved kinds
    send_word(KIND_POP_FRONT, 32'sd5);
    send_word(KIND_POP_REAR, -32'sd5);
    send_word(KIND_LIST, 32'sd0);
    send_word(KIND_PUSH_REAR, 32'sh7fff_ffff);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_word(KIND_POP_REAR, 32'sd0);
    send_word(KIND_PUSH_FRONT, -32'sd1);
    send_word(KIND_PUSH_REAR, 32'sd0);
    send_word(KIND_PUSH_FRONT, 32'sh5555_5555);
    send_word(KIND_PUSH_REAR, 32'shaaaa_aaaa);
    send_word(KIND_LIST, -32'sd1);
    send_word(3'd5, 32'sd1);
    send_word(3'd6, -32'sd1);
    send_word(3'd7, 32'sh7fff_ffff);
    send_word(KIND_POP_REAR, 32'sd0);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_LIST, 32'sd0);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_POP_FRONT, 32'sd0);
    send_word(KIND_LIST, 32'sd0);
    drain_answers();

    // fill past capacity, list the full deque
    repeat (DqDepth + 2) send_word(pick_push(), pick_value());
    send_word(KIND_LIST, pick_value());
    drain_answers();

    done = 0;
    mode = MODE_DRAIN;
    while (done < RANDOM_ITEMS) begin
      quiet = (done >= RANDOM_ITEMS - TAIL_ITEMS);
      if (done % 30 == 0) mode = $urandom_range(0, 2);
      if (!quiet && $urandom_range(0, 49) == 0) drain_answers();
      kind = pick_kind(mode);
      send_word(kind, pick_value());
      if (kind <= KIND_LIST) done++;
    end

    @(negedge clk);
    cmd_valid = 1'b0;
    while (sb.deque_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands (%0d reserved kinds ignored), %0d words checked",
             sb.cmds_noted, sb.ignored_cmds, sb.words_checked);
    $display("Full refusals %0d, empty answers %0d, listed words %0d, mismatches %0d",
             sb.full_refusals, sb.empty_answers, sb.listed_words, sb.error_count);
    if (sb.error_count == 0 && sb.deque_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
tb/deque_sb_pkg.sv
tb/testbench.sv
